// ===== hw/rtl/ewd_pkg.sv =====
// ewd_pkg: shared types, constants and character helpers for the encoded-word decoder
// depends on nothing; imported by ewd_ctrl, ewd_datapath, the top level and the checker
package ewd_pkg;

    localparam int MAX_WORD = 63;
    localparam int LEN_W    = $clog2(MAX_WORD + 1);
    localparam int ADDR_W   = $clog2(MAX_WORD);

    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_QM  = 8'h3F;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_US  = 8'h5F;
    localparam logic [7:0] CH_UQ  = 8'h51;
    localparam logic [7:0] CH_LQ  = 8'h71;
    localparam logic [7:0] CH_UB  = 8'h42;
    localparam logic [7:0] CH_LB  = 8'h62;
    localparam logic [7:0] NIB_MASK = 8'h0F;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    localparam logic [1:0] ADDR_CFG = 2'd0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } ewd_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_decoded;
        logic       out_run_last;
        logic       out_value_end;
    } ewd_out_t;

    typedef enum logic [1:0] {PH_IDLE, PH_EQ, PH_WORD, PH_CLOSE} phase_t;
    typedef enum logic [2:0] {S_WAIT, S_PRE, S_BYTE, S_POST, S_FINAL} ctrl_state_t;
    typedef enum logic [1:0] {PRE_NONE, PRE_FLUSH, PRE_DECODE} pre_t;
    typedef enum logic [1:0] {ACT_NONE, ACT_EMIT, ACT_STORE} act_t;
    typedef enum logic [1:0] {RUN_RAW, RUN_Q, RUN_B} run_mode_t;

    typedef struct packed {
        logic              accept;
        logic              fast_emit;
        logic              store;
        logic              store_from_input;
        logic [ADDR_W-1:0] store_addr;
        logic              run_start;
        run_mode_t         run_mode;
        logic [LEN_W-1:0]  run_lo;
        logic [LEN_W-1:0]  run_hi;
        logic              byte_emit;
        logic              finalize;
    } ewd_cmd_t;

    typedef struct packed {
        logic run_end;
        logic emit_ok;
        logic fin_ok;
        logic out_free;
    } ewd_status_t;

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        return r;
    endfunction

    function automatic logic [6:0] b64_val(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ewd_ram.sv =====
// ewd_ram: generic single-write, single-read ram with registered read data
// depends on nothing
module ewd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hw/rtl/ewd_ctrl.sv =====
// ewd_ctrl: parse state and item sequencer of the encoded-word decoder
// depends on ewd_pkg; drives ewd_datapath through command and status structs
module ewd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ewd_pkg::ewd_in_t     s_data,
    output ewd_pkg::ewd_cmd_t    cmd,
    input  ewd_pkg::ewd_status_t st
);
    import ewd_pkg::*;

    ctrl_state_t       state_reg, state_next;
    phase_t            phase_reg;
    logic [2:0]        qc_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  ts_reg;
    logic              b64_reg;
    logic              bad_reg;
    logic              prevq_reg;
    act_t              act_reg;
    logic              post_reg;
    logic [LEN_W-1:0]  post_len_reg;
    logic [ADDR_W-1:0] store_addr_reg;

    logic accept;
    logic is_eq, is_q, is_ws, go_idle;
    pre_t              pl_pre;
    act_t              pl_act;
    logic [ADDR_W-1:0] pl_addr;
    logic              pl_post;
    run_mode_t         pl_mode;
    logic [LEN_W-1:0]  pl_lo, pl_hi;
    phase_t            n_phase;
    logic [2:0]        n_qc;
    logic [LEN_W-1:0]  n_len, n_ts;
    logic              n_b64, n_bad, n_prevq;

    assign accept = s_valid && s_ready;
    assign is_eq  = s_data.in_byte == CH_EQ;
    assign is_q   = s_data.in_byte == CH_QM;
    assign is_ws  = s_data.in_byte == CH_SP || s_data.in_byte == CH_TAB
                    || s_data.in_byte == CH_LF;

    // what the incoming item does to the word state
    always_comb begin
        pl_pre  = PRE_NONE;
        pl_act  = ACT_EMIT;
        pl_addr = '0;
        pl_mode = RUN_RAW;
        pl_lo   = '0;
        pl_hi   = len_reg;
        n_phase = phase_reg;
        n_qc    = qc_reg;
        n_len   = len_reg;
        n_ts    = ts_reg;
        n_b64   = b64_reg;
        n_bad   = bad_reg;
        n_prevq = prevq_reg;
        go_idle = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                go_idle = 1'b1;
            end
            PH_EQ: begin
                if (is_q) begin
                    pl_act  = ACT_STORE;
                    pl_addr = ADDR_W'(1);
                    n_len   = LEN_W'(2);
                    n_qc    = 3'd1;
                    n_phase = PH_WORD;
                    n_prevq = 1'b1;
                end else begin
                    pl_pre  = PRE_FLUSH;
                    go_idle = 1'b1;
                end
            end
            PH_WORD: begin
                if (is_ws || len_reg >= LEN_W'(MAX_WORD) || len_reg < LEN_W'(2)) begin
                    pl_pre  = PRE_FLUSH;
                    go_idle = 1'b1;
                end else begin
                    if (qc_reg == 3'd2 && prevq_reg) begin
                        if (s_data.in_byte == CH_UQ || s_data.in_byte == CH_LQ) begin
                            n_b64 = 1'b0;
                        end else if (s_data.in_byte == CH_UB || s_data.in_byte == CH_LB) begin
                            n_b64 = 1'b1;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    pl_act  = ACT_STORE;
                    pl_addr = len_reg[ADDR_W-1:0];
                    n_len   = len_reg + LEN_W'(1);
                    n_prevq = is_q;
                    if (is_q) begin
                        n_qc = qc_reg + 3'd1;
                        // empty charset
                        if (n_qc == 3'd2 && n_len == LEN_W'(3)) begin
                            n_bad = 1'b1;
                        end
                        if (n_qc == 3'd3) begin
                            n_ts = n_len;
                        end
                        if (n_qc >= 3'd4) begin
                            n_phase = PH_CLOSE;
                        end
                    end
                end
            end
            PH_CLOSE: begin
                if (!is_eq) begin
                    pl_pre  = PRE_FLUSH;
                    go_idle = 1'b1;
                end else begin
                    if (bad_reg) begin
                        pl_pre = PRE_FLUSH;
                        pl_act = ACT_EMIT;
                    end else begin
                        pl_pre  = PRE_DECODE;
                        pl_act  = ACT_NONE;
                        pl_mode = b64_reg ? RUN_B : RUN_Q;
                        pl_lo   = ts_reg;
                        pl_hi   = len_reg - LEN_W'(1);
                    end
                    n_phase = PH_IDLE;
                    n_qc    = '0;
                    n_len   = '0;
                    n_ts    = '0;
                    n_b64   = 1'b0;
                    n_bad   = 1'b0;
                end
            end
            default: begin
                go_idle = 1'b1;
            end
        endcase
        if (go_idle) begin
            n_phase = PH_IDLE;
            n_qc    = '0;
            n_len   = '0;
            n_ts    = '0;
            n_b64   = 1'b0;
            n_bad   = 1'b0;
            if (is_eq) begin
                pl_act  = ACT_STORE;
                pl_addr = '0;
                n_len   = LEN_W'(1);
                n_phase = PH_EQ;
                n_prevq = 1'b0;
            end else begin
                pl_act = ACT_EMIT;
            end
        end
        pl_post = s_data.in_last && n_phase != PH_IDLE;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_WAIT: begin
                if (accept) begin
                    if (pl_pre != PRE_NONE) begin
                        state_next = S_PRE;
                    end else if (pl_post) begin
                        state_next = S_POST;
                    end
                end
            end
            S_PRE: begin
                if (st.run_end) begin
                    state_next = (act_reg != ACT_NONE) ? S_BYTE : S_FINAL;
                end
            end
            S_BYTE: begin
                if (act_reg == ACT_EMIT) begin
                    if (st.emit_ok) begin
                        state_next = S_FINAL;
                    end
                end else begin
                    state_next = post_reg ? S_POST : S_FINAL;
                end
            end
            S_POST: begin
                if (st.run_end) begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL: begin
                if (st.fin_ok) begin
                    state_next = S_WAIT;
                end
            end
            default: state_next = S_WAIT;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.run_hi  = post_len_reg;
        s_ready     = 1'b0;
        unique case (state_reg)
            S_WAIT: begin
                s_ready    = st.out_free;
                cmd.accept = accept;
                if (accept) begin
                    if (pl_pre != PRE_NONE) begin
                        cmd.run_start = 1'b1;
                        cmd.run_mode  = pl_mode;
                        cmd.run_lo    = pl_lo;
                        cmd.run_hi    = pl_hi;
                    end else if (pl_act == ACT_EMIT) begin
                        cmd.fast_emit = 1'b1;
                    end else begin
                        cmd.store            = 1'b1;
                        cmd.store_from_input = 1'b1;
                        cmd.store_addr       = pl_addr;
                        cmd.run_start        = pl_post;
                        cmd.run_hi           = n_len;
                    end
                end
            end
            S_PRE, S_POST: begin
            end
            S_BYTE: begin
                if (act_reg == ACT_EMIT) begin
                    cmd.byte_emit = 1'b1;
                end else begin
                    cmd.store      = 1'b1;
                    cmd.store_addr = store_addr_reg;
                    cmd.run_start  = post_reg;
                end
            end
            S_FINAL: begin
                cmd.finalize = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_WAIT;
            phase_reg      <= PH_IDLE;
            qc_reg         <= '0;
            len_reg        <= '0;
            ts_reg         <= '0;
            b64_reg        <= 1'b0;
            bad_reg        <= 1'b0;
            prevq_reg      <= 1'b0;
            act_reg        <= ACT_NONE;
            post_reg       <= 1'b0;
            post_len_reg   <= '0;
            store_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                phase_reg      <= pl_post ? PH_IDLE : n_phase;
                qc_reg         <= pl_post ? 3'd0 : n_qc;
                len_reg        <= pl_post ? '0 : n_len;
                ts_reg         <= pl_post ? '0 : n_ts;
                b64_reg        <= pl_post ? 1'b0 : n_b64;
                bad_reg        <= pl_post ? 1'b0 : n_bad;
                prevq_reg      <= n_prevq;
                act_reg        <= pl_act;
                post_reg       <= pl_post;
                post_len_reg   <= n_len;
                store_addr_reg <= pl_addr;
            end
        end
    end
endmodule

// ===== hw/rtl/ewd_datapath.sv =====
// ewd_datapath: word buffer, read window, q/base64 decode and result staging
// depends on ewd_pkg and ewd_ram; commanded by ewd_ctrl
module ewd_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  us_cfg,
    input  ewd_pkg::ewd_in_t      s_data,
    input  ewd_pkg::ewd_cmd_t     cmd,
    output ewd_pkg::ewd_status_t  st,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ewd_pkg::ewd_out_t     m_data
);
    import ewd_pkg::*;

    logic [7:0]        byte_reg;
    logic              last_reg;
    logic              act_reg;
    run_mode_t         mode_reg;
    logic [ADDR_W-1:0] fptr_reg;
    logic [LEN_W-1:0]  fleft_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [7:0]        win_reg [4];
    logic [7:0]        win_next [4];
    logic [7:0]        win_sh [4];
    logic [2:0]        cnt_reg, cnt_next, cnt_after;
    logic              rdp_reg;
    logic [1:0]        sub_reg;
    logic              pend_valid_reg;
    logic [7:0]        pend_byte_reg;
    logic              pend_dec_reg;
    logic              m_valid_reg;
    ewd_out_t          m_data_reg;

    logic [7:0] rdata;
    logic       issue;
    logic       run_req, run_dec, stop, out_free, emit_req, fire;
    logic [7:0] run_byte, emit_byte;
    logic       emit_dec;
    logic [2:0] pop, p;
    logic [4:0] hh, hl;
    logic [6:0] ba, bb, bc, bd;
    logic       eq2, eq3, q_bad;
    logic [1:0] q_n;
    logic [23:0] qv;
    logic       load_out;
    ewd_out_t   out_new;

    ewd_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_buf (
        .aclk  (aclk),
        .we    (cmd.store),
        .waddr (cmd.store_addr),
        .wdata (cmd.store_from_input ? s_data.in_byte : byte_reg),
        .re    (issue),
        .raddr (fptr_reg),
        .rdata (rdata)
    );

    assign issue = act_reg && fleft_reg != '0 && (cnt_reg + {2'b0, rdp_reg}) < 3'd4;

    // base64 quartet at the head of the window
    assign ba  = b64_val(win_reg[0]);
    assign bb  = b64_val(win_reg[1]);
    assign bc  = b64_val(win_reg[2]);
    assign bd  = b64_val(win_reg[3]);
    assign eq2 = win_reg[2] == CH_EQ;
    assign eq3 = win_reg[3] == CH_EQ;
    assign q_bad = !ba[6] || !bb[6] || (eq2 ? !eq3 : (!bc[6] || (!eq3 && !bd[6])));
    assign q_n   = eq2 ? 2'd1 : (eq3 ? 2'd2 : 2'd3);
    assign qv    = {ba[5:0], bb[5:0], eq2 ? 6'd0 : bc[5:0], (eq2 || eq3) ? 6'd0 : bd[5:0]};
    assign hh    = hex_val(win_reg[1]);
    assign hl    = hex_val(win_reg[2]);

    always_comb begin
        run_req  = 1'b0;
        run_byte = win_reg[0];
        run_dec  = 1'b1;
        pop      = 3'd0;
        stop     = 1'b0;
        if (act_reg && rem_reg != '0) begin
            unique case (mode_reg)
                RUN_RAW: begin
                    run_dec = 1'b0;
                    if (cnt_reg != 3'd0) begin
                        run_req = 1'b1;
                        pop     = 3'd1;
                    end
                end
                RUN_Q: begin
                    if (cnt_reg != 3'd0) begin
                        if (win_reg[0] == CH_EQ && rem_reg >= LEN_W'(3)) begin
                            if (cnt_reg >= 3'd3) begin
                                run_req = 1'b1;
                                if (hh[4] && hl[4]) begin
                                    run_byte = (({4'd0, hh[3:0]} & NIB_MASK) << 4)
                                               | ({4'd0, hl[3:0]} & NIB_MASK);
                                    pop = 3'd3;
                                end else begin
                                    pop = 3'd1;
                                end
                            end
                        end else begin
                            run_req = 1'b1;
                            pop     = 3'd1;
                            if (win_reg[0] == CH_US && us_cfg) begin
                                run_byte = CH_SP;
                            end
                        end
                    end
                end
                RUN_B: begin
                    if (rem_reg < LEN_W'(4)) begin
                        stop = 1'b1;
                    end else if (cnt_reg == 3'd4) begin
                        if (q_bad) begin
                            stop = 1'b1;
                        end else begin
                            run_req = 1'b1;
                            unique case (sub_reg)
                                2'd0:    run_byte = qv[23:16];
                                2'd1:    run_byte = qv[15:8] & BYTE_MASK;
                                default: run_byte = qv[7:0] & BYTE_MASK;
                            endcase
                            pop = (sub_reg == q_n - 2'd1) ? 3'd4 : 3'd0;
                        end
                    end
                end
                default: stop = 1'b1;
            endcase
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign emit_req  = run_req || cmd.byte_emit;
    assign emit_byte = cmd.byte_emit ? byte_reg : run_byte;
    assign emit_dec  = cmd.byte_emit ? 1'b0 : run_dec;
    assign fire      = emit_req && (!pend_valid_reg || out_free);

    assign st.run_end  = act_reg && (rem_reg == '0 || stop);
    assign st.emit_ok  = !pend_valid_reg || out_free;
    assign st.fin_ok   = !pend_valid_reg || out_free;
    assign st.out_free = out_free;

    // window shift by the consumed count, then append returning read data
    always_comb begin
        p = (fire && run_req) ? pop : 3'd0;
        cnt_after = cnt_reg - p;
        for (int k = 0; k < 4; k++) begin
            win_sh[k] = win_reg[k];
        end
        unique case (p)
            3'd1: begin
                win_sh[0] = win_reg[1];
                win_sh[1] = win_reg[2];
                win_sh[2] = win_reg[3];
            end
            3'd3: begin
                win_sh[0] = win_reg[3];
            end
            default: begin
            end
        endcase
        for (int k = 0; k < 4; k++) begin
            win_next[k] = win_sh[k];
        end
        cnt_next = cnt_after;
        if (rdp_reg && act_reg) begin
            win_next[cnt_after[1:0]] = rdata;
            cnt_next = cnt_after + 3'd1;
        end
    end

    always_comb begin
        load_out = 1'b0;
        out_new  = '0;
        if (cmd.fast_emit) begin
            load_out = 1'b1;
            out_new  = '{out_byte: s_data.in_byte, out_decoded: 1'b0,
                         out_run_last: 1'b1, out_value_end: s_data.in_last};
        end else if (fire && pend_valid_reg) begin
            load_out = 1'b1;
            out_new  = '{out_byte: pend_byte_reg, out_decoded: pend_dec_reg,
                         out_run_last: 1'b0, out_value_end: 1'b0};
        end else if (cmd.finalize && pend_valid_reg && out_free) begin
            load_out = 1'b1;
            out_new  = '{out_byte: pend_byte_reg, out_decoded: pend_dec_reg,
                         out_run_last: 1'b1, out_value_end: last_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg        <= 1'b0;
            mode_reg       <= RUN_RAW;
            fleft_reg      <= '0;
            rem_reg        <= '0;
            cnt_reg        <= '0;
            rdp_reg        <= 1'b0;
            sub_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.run_start) begin
                act_reg   <= 1'b1;
                mode_reg  <= cmd.run_mode;
                fleft_reg <= cmd.run_hi - cmd.run_lo;
                rem_reg   <= cmd.run_hi - cmd.run_lo;
                cnt_reg   <= '0;
                rdp_reg   <= 1'b0;
                sub_reg   <= '0;
            end else begin
                if (st.run_end) begin
                    act_reg <= 1'b0;
                end
                rdp_reg <= issue;
                if (issue) begin
                    fleft_reg <= fleft_reg - LEN_W'(1);
                end
                rem_reg <= rem_reg - LEN_W'(p);
                cnt_reg <= cnt_next;
                if (fire && run_req && mode_reg == RUN_B) begin
                    sub_reg <= (pop != 3'd0) ? 2'd0 : sub_reg + 2'd1;
                end
            end
            if (fire) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.finalize && st.fin_ok) begin
                pend_valid_reg <= 1'b0;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg <= s_data.in_byte;
            last_reg <= s_data.in_last;
        end
        if (cmd.run_start) begin
            fptr_reg <= cmd.run_lo[ADDR_W-1:0];
        end else if (issue) begin
            fptr_reg <= fptr_reg + ADDR_W'(1);
        end
        for (int k = 0; k < 4; k++) begin
            win_reg[k] <= win_next[k];
        end
        if (fire) begin
            pend_byte_reg <= emit_byte;
            pend_dec_reg  <= emit_dec;
        end
        if (load_out) begin
            m_data_reg <= out_new;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule

// ===== hw/rtl/rfc2047_encoded_word_decoder.sv =====
// rfc2047_encoded_word_decoder: top level and apb register, built on ewd_pkg, ewd_ctrl, ewd_datapath
// latency: a passed-through byte is in the result register right after the edge that takes it
// throughput: one item per cycle while bytes pass through or go into the word buffer and the result
// register can move; an item that releases buffered bytes holds the input until they are all out
// base64 text waits for a full four-byte window per quartet; output stalls slow the release
// reset: aresetn synchronous active low; clears parse state and output valid, underscore mode 1
module rfc2047_encoded_word_decoder (
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  ewd_pkg::ewd_in_t  s_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output ewd_pkg::ewd_out_t m_data,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ewd_pkg::*;

    ewd_cmd_t    cmd;
    ewd_status_t st;
    logic        us_reg;

    // underscore-as-space mode, only register of the block
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CFG) ? {31'd0, us_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            us_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_CFG) begin
            us_reg <= pwdata[0];
        end
    end

    // controller: word state machine, decides per item what to flush, decode or keep
    ewd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cmd     (cmd),
        .st      (st)
    );

    // datapath: word buffer, streaming decoder and the output item register
    ewd_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .us_cfg  (us_reg),
        .s_data  (s_data),
        .cmd     (cmd),
        .st      (st),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );
endmodule

// ===== hw/rtl/ewd_checker.sv =====
// ewd_checker: port-level assertions for the encoded-word decoder
// depends on ewd_pkg; bound to rfc2047_encoded_word_decoder
module ewd_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input ewd_pkg::ewd_out_t m_data
);
    import ewd_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // end of value only on the last result of an item
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_value_end |-> m_data.out_run_last)
        else $error("value end without run last");

    // a new item is only taken when the output register can move
    a_ready_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready))
        else $error("input taken with blocked output");

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind rfc2047_encoded_word_decoder ewd_checker u_ewd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/rfc2047_encoded_word_decoder_tb.sv =====
// rfc2047_encoded_word_decoder_tb: self-checking testbench for the encoded-word decoder
// depends on ewd_pkg and the rfc2047_encoded_word_decoder rtl
`timescale 1ns / 1ps

// queue of expected output bytes, filled by a behavioral decoder
class ewd_scoreboard;
    ewd_pkg::ewd_out_t pending[$];
    bit                us_mode;
    ewd_pkg::phase_t   phase;
    int unsigned       qcount;
    logic [7:0]        wbuf[ewd_pkg::MAX_WORD];
    int unsigned       wlen;
    int unsigned       tstart;
    bit                is_b64;
    bit                bad;
    ewd_pkg::ewd_out_t step_out[$];
    int                errors;
    int                checked;
    int                decoded_seen;

    function new();
        us_mode = 1'b1;
        clear_word();
    endfunction

    function void clear_word();
        phase  = ewd_pkg::PH_IDLE;
        qcount = 0;
        wlen   = 0;
        tstart = 0;
        is_b64 = 0;
        bad    = 0;
    endfunction

    function void put(logic [7:0] b, bit dec);
        ewd_pkg::ewd_out_t r;
        if (step_out.size() >= 64) return;
        r = '0;
        r.out_byte = b;
        r.out_decoded = dec;
        step_out.push_back(r);
    endfunction

    function void flush_raw();
        for (int i = 0; i < wlen; i++) put(wbuf[i], 0);
        clear_word();
    endfunction

    function int hexv(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 10;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return -1;
    endfunction

    function int b64v(logic [7:0] c);
        if (c >= "A" && c <= "Z") return c - "A";
        if (c >= "a" && c <= "z") return c - "a" + 26;
        if (c >= "0" && c <= "9") return c - "0" + 52;
        if (c == "+") return 62;
        if (c == "/") return 63;
        return -1;
    endfunction

    function void decode_word();
        int unsigned te, i;
        int a, b, c, d, h, l;
        logic [23:0] v;
        logic [7:0] ch;
        te = (wlen > 0) ? wlen - 1 : 0;
        if (is_b64) begin
            for (i = tstart; i + 4 <= te; i += 4) begin
                a = b64v(wbuf[i]);
                b = b64v(wbuf[i+1]);
                c = b64v(wbuf[i+2]);
                d = b64v(wbuf[i+3]);
                if (a < 0 || b < 0) break;
                v = {a[5:0], b[5:0], 12'd0};
                if (wbuf[i+2] == ewd_pkg::CH_EQ) begin
                    if (wbuf[i+3] != ewd_pkg::CH_EQ) break;
                    put(v[23:16], 1);
                    continue;
                end
                if (c < 0) break;
                v[11:6] = c[5:0];
                if (wbuf[i+3] == ewd_pkg::CH_EQ) begin
                    put(v[23:16], 1);
                    put(v[15:8], 1);
                    continue;
                end
                if (d < 0) break;
                v[5:0] = d[5:0];
                put(v[23:16], 1);
                put(v[15:8], 1);
                put(v[7:0], 1);
            end
        end else begin
            i = tstart;
            while (i < te) begin
                ch = wbuf[i];
                if (ch == ewd_pkg::CH_EQ && i + 2 < te) begin
                    h = hexv(wbuf[i+1]);
                    l = hexv(wbuf[i+2]);
                    if (h >= 0 && l >= 0) begin
                        put({h[3:0], l[3:0]}, 1);
                        i += 3;
                        continue;
                    end
                end
                if (ch == ewd_pkg::CH_US && us_mode) ch = ewd_pkg::CH_SP;
                put(ch, 1);
                i++;
            end
        end
        clear_word();
    endfunction

    function void idle_byte(logic [7:0] b);
        if (b == ewd_pkg::CH_EQ) begin
            wbuf[0] = b;
            wlen = 1;
            phase = ewd_pkg::PH_EQ;
        end else begin
            put(b, 0);
        end
    endfunction

    function void word_byte(logic [7:0] b);
        if (b == ewd_pkg::CH_SP || b == ewd_pkg::CH_TAB || b == ewd_pkg::CH_LF ||
            wlen >= ewd_pkg::MAX_WORD || wlen < 2) begin
            flush_raw();
            idle_byte(b);
            return;
        end
        if (qcount == 2 && wbuf[wlen-1] == ewd_pkg::CH_QM) begin
            if (b == ewd_pkg::CH_UQ || b == ewd_pkg::CH_LQ) is_b64 = 0;
            else if (b == ewd_pkg::CH_UB || b == ewd_pkg::CH_LB) is_b64 = 1;
            else bad = 1;
        end
        wbuf[wlen] = b;
        wlen++;
        if (b == ewd_pkg::CH_QM) begin
            qcount++;
            if (qcount == 2 && wlen == 3) bad = 1;
            if (qcount == 3) tstart = wlen;
            if (qcount >= 4) phase = ewd_pkg::PH_CLOSE;
        end
    endfunction

    // note an accepted input item and queue what it produces
    function void note_input(ewd_pkg::ewd_in_t it);
        logic [7:0] b;
        b = it.in_byte;
        step_out.delete();
        case (phase)
            ewd_pkg::PH_EQ: begin
                if (b == ewd_pkg::CH_QM) begin
                    wbuf[1] = b;
                    wlen = 2;
                    qcount = 1;
                    phase = ewd_pkg::PH_WORD;
                end else begin
                    flush_raw();
                    idle_byte(b);
                end
            end
            ewd_pkg::PH_WORD: word_byte(b);
            ewd_pkg::PH_CLOSE: begin
                if (b != ewd_pkg::CH_EQ) begin
                    flush_raw();
                    idle_byte(b);
                end else if (bad) begin
                    flush_raw();
                    put(b, 0);
                end else begin
                    decode_word();
                end
            end
            default: begin
                clear_word();
                idle_byte(b);
            end
        endcase
        if (it.in_last && phase != ewd_pkg::PH_IDLE) flush_raw();
        if (step_out.size() > 0) begin
            step_out[$].out_run_last = 1'b1;
            step_out[$].out_value_end = it.in_last;
        end
        foreach (step_out[k]) pending.push_back(step_out[k]);
    endfunction

    function void report(string what);
        $display("mismatch: %s", what);
        errors++;
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(ewd_pkg::ewd_out_t got);
        ewd_pkg::ewd_out_t exp_r;
        checked++;
        if (got.out_decoded) decoded_seen++;
        if (pending.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
        end
        exp_r = pending.pop_front();
        if (got.out_byte !== exp_r.out_byte)
            report($sformatf("out_byte got %h exp %h", got.out_byte, exp_r.out_byte));
        if (got.out_decoded !== exp_r.out_decoded)
            report($sformatf("out_decoded got %b exp %b", got.out_decoded, exp_r.out_decoded));
        if (got.out_run_last !== exp_r.out_run_last)
            report($sformatf("out_run_last got %b exp %b", got.out_run_last, exp_r.out_run_last));
        if (got.out_value_end !== exp_r.out_value_end)
            report($sformatf("out_value_end got %b exp %b",
                             got.out_value_end, exp_r.out_value_end));
    endfunction
endclass

module rfc2047_encoded_word_decoder_tb;
    import ewd_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    ewd_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    ewd_out_t    m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ewd_scoreboard sb;
    int  send_idle_pct;   // sender gap chance in percent
    int  recv_idle_pct;   // receiver stall chance in percent
    int  hold_reqs;       // count of long receiver hold-off requests
    int  items_sent;

    rfc2047_encoded_word_decoder u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit, far above the slowest correct run
    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    // result side: random stalls, plus one long hold-off per request
    initial begin
        int hold_cnt;
        int hold_seen;
        m_ready = 1'b0;
        hold_cnt = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_data);
            if (hold_reqs != hold_seen && hold_cnt == 0) begin
                hold_seen = hold_reqs;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // one apb write: setup then access
    task automatic reg_write(input logic [1:0] addr, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (val[0] !== 1'bx) sb.us_mode = val[0];
    endtask

    // offer one item and hold it until taken; the next item may follow at once
    task automatic send_item(input logic [7:0] b, input logic last);
        ewd_in_t it;
        it.in_byte = b;
        it.in_last = last;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        items_sent++;
    endtask

    // drop valid after the last item of a burst
    task automatic stop_input();
        s_valid <= 1'b0;
    endtask

    task automatic send_str(input string s, input bit last);
        for (int i = 0; i < s.len(); i++) send_item(s[i], last && i == s.len() - 1);
    endtask

    // wait for all expected results, then for in-flight work to settle
    task automatic drain();
        int guard;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (150) @(posedge aclk);
    endtask

    function automatic byte rand_b64();
        int v;
        v = $urandom_range(63);
        if (v < 26) return byte'("A" + v);
        if (v < 52) return byte'("a" + v - 26);
        if (v < 62) return byte'("0" + v - 52);
        return (v == 62) ? "+" : "/";
    endfunction

    function automatic byte rand_hex();
        int v;
        v = $urandom_range(15);
        return (v < 10) ? byte'("0" + v)
                        : byte'((($urandom_range(1) != 0) ? "A" : "a") + v - 10);
    endfunction

    // random well-formed word with occasional corruption
    task automatic send_rand_word(input bit last);
        string w;
        string t;
        int n;
        bit b64;
        b64 = ($urandom_range(1) != 0);
        t = "";
        n = $urandom_range(1, 4);
        if (b64) begin
            for (int i = 0; i < n; i++) begin
                t = {t, string'(rand_b64()), string'(rand_b64())};
                case ($urandom_range(3))
                    0: t = {t, "=="};
                    1: t = {t, string'(rand_b64()), "="};
                    default: t = {t, string'(rand_b64()), string'(rand_b64())};
                endcase
                if (t.len() > 40) break;
            end
        end else begin
            for (int i = 0; i < n * 2; i++) begin
                case ($urandom_range(5))
                    0: t = {t, "=", string'(rand_hex()), string'(rand_hex())};
                    1: t = {t, "_"};
                    2: t = {t, "=", string'(byte'($urandom_range(33, 126)))};
                    default: t = {t, string'(byte'($urandom_range(33, 126)))};
                endcase
            end
        end
        if (t.len() > 48) t = t.substr(0, 47);
        w = {"=?", ($urandom_range(4) == 0) ? "" : "utf-8", "?",
             b64 ? ($urandom_range(1) ? "B" : "b") : ($urandom_range(1) ? "Q" : "q"),
             "?", t, "?="};
        if ($urandom_range(7) == 0) w[$urandom_range(w.len() - 1)] = byte'($urandom_range(255));
        send_str(w, last);
    endtask

    initial begin
        int  base;
        bit  hold_done;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        s_valid = 0; s_data = '0;
        hold_reqs = 0;
        hold_done = 0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sb = new();
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, lone equals, q escapes, empty charset, bad letter
        send_item(8'h00, 0);
        send_item(8'hFF, 0);
        send_str("=x", 0);
        send_str("=?a?Q?h_=41=zz?=", 0);
        send_str("=??Q?x?=", 0);
        send_str("=?a?Z?x?=", 1);
        stop_input();
        drain();

        // underscore kept literal, base64 padding, missing close, whitespace
        reg_write(ADDR_CFG, 32'd0);
        send_str("=?c?q?a_b?=", 0);
        send_str("=?c?b?QQ==QUI=?=", 0);
        send_str("=?c?Q?ab?x", 0);
        send_str("=?c?Q?ab\tz", 1);
        stop_input();
        drain();
        reg_write(ADDR_CFG, 32'd1);

        // overlong word, then a word left open at end of value
        begin
            string s;
            s = "=?c?Q?";
            for (int i = 0; i < 57; i++) s = {s, "x"};
            send_str(s, 0);
            send_str("=?c?Q?abc", 1);
        end
        stop_input();
        drain();

        // random phase with idling on both sides and one stretch without
        base = items_sent;
        while (items_sent - base < 70) begin
            if (items_sent - base >= 25 && items_sent - base < 50) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = 32;
                recv_idle_pct = 32;
            end
            if (!hold_done && items_sent - base >= 8) begin
                hold_reqs++;
                hold_done = 1;
            end
            case ($urandom_range(9))
                0, 1: send_item(8'($urandom_range(255)), $urandom_range(7) == 0);
                2: send_str(" ", 0);
                default: send_rand_word($urandom_range(5) == 0);
            endcase
            if ($urandom_range(15) == 0) begin
                // sender waits for every expected result, then maybe flips the mode
                send_item("x", 1);
                stop_input();
                drain();
                reg_write(ADDR_CFG, {31'd0, 1'($urandom_range(1))});
            end
        end
        send_item("e", 1);
        stop_input();
        drain();

        $display("covered directed q and base64 words, raw flushes and random words under");
        $display("idling and a long output hold-off: %0d items, %0d results, %0d decoded",
                 items_sent, sb.checked, sb.decoded_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
